### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define XX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define XX_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/xxtea_pkg.sv
// Shared constants, types and tables of the XXTEA engine.
package xxtea_pkg;

  localparam int MAX_WORDS = 16;
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int RND_W     = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] DELTA_RESET = 32'h9e3779b9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd6;

  // Operands of one mix evaluation.
  typedef struct packed {
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    logic [31:0] key;
  } mix_req_t;

  // Full cycles over the block: 6 + 52 / n.
  function automatic logic [RND_W-1:0] rounds_for(input logic [CNT_W-1:0] n);
    logic [RND_W-1:0] r;
    case (n)
      5'd2:    r = 6'd32;
      5'd3:    r = 6'd23;
      5'd4:    r = 6'd19;
      5'd5:    r = 6'd16;
      5'd6:    r = 6'd14;
      5'd7:    r = 6'd13;
      5'd8:    r = 6'd12;
      5'd9:    r = 6'd11;
      5'd10:   r = 6'd11;
      5'd11:   r = 6'd10;
      5'd12:   r = 6'd10;
      5'd13:   r = 6'd10;
      5'd14:   r = 6'd9;
      5'd15:   r = 6'd9;
      5'd16:   r = 6'd9;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

endpackage

### design/xxtea_mix_unit.sv
// Shared XXTEA mix function unit with registered result.
module xxtea_mix_unit (
  input  logic                clk,
  input  logic                en,
  input  xxtea_pkg::mix_req_t req,
  output logic [31:0]         mix
);
  import xxtea_pkg::*;

  logic [31:0] lhs;
  logic [31:0] rhs;

  // Two adds side by side, then xor.
  assign lhs = ((req.z >> 5) ^ (req.y << 2)) + ((req.y >> 3) ^ (req.z << 4));
  assign rhs = (req.sum ^ req.y) + (req.key ^ req.z);

  always_ff @(posedge clk) begin
    if (en) begin
      mix <= lhs ^ rhs;
    end
  end

endmodule

### design/xxtea_block_cipher_top.sv
// XXTEA block cipher engine top level: block store, sequencer and config registers.
//
// Data words arrive one beat at a time on the input channel (in_valid/in_stall)
// and are written to a 16-entry block store. When the fill count reaches the
// effective block size n (block_words clamped to 2..16) the engine runs
// 6 + 52/n full rounds of the XXTEA mix over the block, encrypting or
// decrypting per the direction register with the 128-bit key and delta;
// on decrypt the running sum starts at rounds * delta mod 2^32. The
// processed block then leaves on the output channel (out_valid/out_stall) in
// index order, last_word set on word n-1. Filling takes one word per beat.
// Processing a block starts with store reads in ST_LD1, ST_LD2 and ST_LD3;
// each word update then passes through the shared mix unit (ST_MIX) and the
// add/subtract and store write (ST_UPD), with the next neighbor read from
// the single-read-port store in the same cycle. Emitting reads each word
// from the store, then loads it into the output register, waiting while the
// sink stalls. in_stall is high after the beat that completes a block until
// the last word is loaded into the output register; that last word may
// still wait for the sink while new words are accepted. Config registers
// are written through cfg_write_en/cfg_index/cfg_data and must only change
// while the engine is idle. There is no clearing pass after reset.
module xxtea_block_cipher_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [31:0]                       data_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       result_word,
  output logic                              last_word
);
  import xxtea_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LD1  = 3'd1;  // read first z/y seed word
  localparam logic [2:0] ST_LD2  = 3'd2;  // read first word to update
  localparam logic [2:0] ST_LD3  = 3'd3;  // read its neighbor
  localparam logic [2:0] ST_MIX  = 3'd4;  // mix unit busy
  localparam logic [2:0] ST_UPD  = 3'd5;  // add/sub, write back, read next neighbor
  localparam logic [2:0] ST_ORD  = 3'd6;  // read word for output
  localparam logic [2:0] ST_OWT  = 3'd7;  // load output register

  // Config registers.
  logic [31:0]      key [4];
  logic [31:0]      delta;
  logic [4:0]       block_words;
  logic             direction;

  // Control state.
  logic [2:0]       state;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] nreg;
  logic [RND_W-1:0] rounds;
  logic [IDX_W-1:0] p;
  logic [IDX_W-1:0] q;
  logic [IDX_W-1:0] oidx;

  // Datapath registers.
  logic [31:0]      sum;
  logic [31:0]      zreg;
  logic [31:0]      yreg;
  logic [31:0]      cur;
  logic [31:0]      rdata;
  logic [31:0]      mixv;

  // Block store.
  logic [31:0]      mem [MAX_WORDS];

  logic             in_take;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] n_last;
  logic [IDX_W-1:0] p_next;
  logic [IDX_W-1:0] q_next;
  logic             round_end;
  logic [31:0]      upd_val;
  logic [1:0]       kidx;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic             out_load;
  mix_req_t         req;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign fill_next = fill + CNT_W'(1);

  // Clamp block size to 2..MAX_WORDS.
  always_comb begin
    n_eff = block_words;
    if (block_words < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (block_words > CNT_W'(MAX_WORDS)) begin
      n_eff = CNT_W'(MAX_WORDS);
    end
  end

  assign n_last = IDX_W'(nreg - CNT_W'(1));

  // Word and neighbor pointers walk up on encrypt, down on decrypt, modulo n.
  always_comb begin
    if (direction) begin
      p_next    = (p == '0) ? n_last : p - IDX_W'(1);
      q_next    = (q == '0) ? n_last : q - IDX_W'(1);
      round_end = (p == '0);
    end else begin
      p_next    = (p == n_last) ? '0 : p + IDX_W'(1);
      q_next    = (q == n_last) ? '0 : q + IDX_W'(1);
      round_end = (p == n_last);
    end
  end

  assign upd_val = direction ? (cur - mixv) : (cur + mixv);
  assign kidx    = p[1:0] ^ sum[3:2];

  // Encrypt: y is the freshly read neighbor, z the last written word.
  // Decrypt: z is the freshly read neighbor, y the last written word.
  always_comb begin
    req.y   = direction ? yreg : rdata;
    req.z   = direction ? rdata : zreg;
    req.sum = sum;
    req.key = key[kidx];
  end

  xxtea_mix_unit u_mix (
    .clk (clk),
    .en  (state == ST_MIX),
    .req (req),
    .mix (mixv)
  );

  // Store write port: input fill or round write back.
  always_comb begin
    we    = 1'b0;
    waddr = fill[IDX_W-1:0];
    wdata = data_word;
    if (in_take) begin
      we = 1'b1;
    end else if (state == ST_UPD) begin
      we    = 1'b1;
      waddr = p;
      wdata = upd_val;
    end
  end

  // Store read port.
  always_comb begin
    re    = 1'b0;
    raddr = p;
    case (state)
      ST_LD1: begin
        re    = 1'b1;
        raddr = direction ? '0 : n_last;
      end
      ST_LD2: begin
        re    = 1'b1;
        raddr = p;
      end
      ST_LD3: begin
        re    = 1'b1;
        raddr = q;
      end
      ST_UPD: begin
        re    = 1'b1;
        raddr = q_next;
      end
      ST_ORD: begin
        re    = 1'b1;
        raddr = oidx;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Write-through on a same-address read: a two-word block reads back the
  // word written in the same cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key[0]      <= '0;
      key[1]      <= '0;
      key[2]      <= '0;
      key[3]      <= '0;
      delta       <= DELTA_RESET;
      block_words <= 5'd2;
      direction   <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_KEY0:      key[0]      <= cfg_data;
        REG_KEY1:      key[1]      <= cfg_data;
        REG_KEY2:      key[2]      <= cfg_data;
        REG_KEY3:      key[3]      <= cfg_data;
        REG_DELTA:     delta       <= cfg_data;
        REG_WORDS:     block_words <= cfg_data[4:0];
        REG_DIRECTION: direction   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign out_load = (state == ST_OWT) && (!out_valid || !out_stall);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      nreg   <= CNT_W'(2);
      rounds <= '0;
      p      <= '0;
      q      <= '0;
      oidx   <= '0;
      sum    <= '0;
      zreg   <= '0;
      yreg   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            // block completes as soon as the count reaches the size
            if (fill_next >= n_eff) begin
              fill   <= '0;
              nreg   <= n_eff;
              rounds <= rounds_for(n_eff);
              state  <= ST_LD1;
            end else begin
              fill <= fill_next;
            end
          end
        end
        ST_LD1: begin
          if (direction) begin
            sum <= 32'(rounds * delta);
            p   <= n_last;
            q   <= n_last - IDX_W'(1);
          end else begin
            sum <= delta;
            p   <= '0;
            q   <= IDX_W'(1);
          end
          state <= ST_LD2;
        end
        ST_LD2: begin
          if (direction) begin
            yreg <= rdata;
          end else begin
            zreg <= rdata;
          end
          state <= ST_LD3;
        end
        ST_LD3: begin
          cur   <= rdata;
          state <= ST_MIX;
        end
        ST_MIX: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (direction) begin
            yreg <= upd_val;
          end else begin
            zreg <= upd_val;
          end
          cur <= rdata;
          p   <= p_next;
          q   <= q_next;
          if (round_end) begin
            rounds <= rounds - RND_W'(1);
            sum    <= direction ? (sum - delta) : (sum + delta);
          end
          if (round_end && (rounds == RND_W'(1))) begin
            oidx  <= '0;
            state <= ST_ORD;
          end else begin
            state <= ST_MIX;
          end
        end
        ST_ORD: begin
          state <= ST_OWT;
        end
        ST_OWT: begin
          if (out_load) begin
            if (oidx == n_last) begin
              state <= ST_IDLE;
            end else begin
              oidx  <= oidx + IDX_W'(1);
              state <= ST_ORD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_word <= rdata;
      last_word   <= (oidx == n_last);
    end
  end

endmodule

### design/xxtea_checker.sv
// Port-level checks of the XXTEA engine, bound to the top level.
module xxtea_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result_word,
  input logic        last_word
);
`include "assert_macros.svh"

  // A stalled result beat holds its payload.
  `XX_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(result_word) && $stable(last_word),
    "stalled result beat changed")

  // While a non-final word waits, the rest of the block is still in flight.
  `XX_ASSERT(a_mid_block_busy, out_valid && !last_word |-> in_stall, "input open in mid block")

  // Input reopens only with the final word loaded.
  `XX_ASSERT(a_reopen_last,
    $fell(in_stall) && !$past(rst) |-> out_valid && last_word,
    "input reopened without final word")

  // Reset leaves the engine idle and empty.
  `XX_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind xxtea_block_cipher_top xxtea_checker u_xxtea_checker (.*);
